// ----- design/qn_pkg.sv -----
// ----------------------------------------------------------------------------
// qn_pkg
// Shared constants and types for the quaternion normaliser.
// ----------------------------------------------------------------------------
package qn_pkg;

    localparam int COMPONENT_WIDTH = 16;
    localparam int FRACTION_BITS   = 14;
    localparam int LANES           = 4;

    // per-word flags that ride alongside the datapath
    typedef struct packed {
        logic             zero;
        logic [LANES-1:0] neg;
    } qn_flags_t;

endpackage

// ----- design/qn_sumsq.sv -----
// ----------------------------------------------------------------------------
// qn_sumsq
// Three-stage front end: magnitudes, squares, sum of squares.
// ----------------------------------------------------------------------------
module qn_sumsq #(
    parameter int CW = qn_pkg::COMPONENT_WIDTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic [qn_pkg::LANES*CW-1:0]     in_comp,
    output logic                            out_valid,
    output logic [2*CW:0]                   out_sum,
    output logic [qn_pkg::LANES*CW-1:0]     out_mag,
    output qn_pkg::qn_flags_t               out_flags
);

    localparam int L = qn_pkg::LANES;

    logic [2:0]        valid_reg;
    logic [CW-1:0]     mag1_reg [0:L-1];
    logic [L-1:0]      neg1_reg;
    logic [2*CW-1:0]   sq_reg   [0:L-1];
    logic [CW-1:0]     mag2_reg [0:L-1];
    logic [L-1:0]      neg2_reg;
    logic [2*CW:0]     sum_reg;
    logic [L*CW-1:0]   mag3_reg;
    qn_pkg::qn_flags_t flags_reg;
    logic [2*CW:0]     sum_next;
    logic              zero_next;

    always_comb
    begin
        sum_next  = '0;
        zero_next = 1'b1;
        for (int i = 0; i < L; i++)
        begin
            sum_next = sum_next + (2*CW+1)'(sq_reg[i]);
            if (mag2_reg[i] != '0)
            begin
                zero_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < L; i++)
        begin
            // two's complement magnitude; the most negative code maps to 2^(CW-1)
            neg1_reg[i] <= in_comp[i*CW + CW - 1];
            mag1_reg[i] <= in_comp[i*CW + CW - 1] ? (~in_comp[i*CW +: CW] + 1'b1)
                                                  : in_comp[i*CW +: CW];
            sq_reg[i]   <= mag1_reg[i] * mag1_reg[i];
            mag2_reg[i] <= mag1_reg[i];
            mag3_reg[i*CW +: CW] <= mag2_reg[i];
        end
        neg2_reg       <= neg1_reg;
        sum_reg        <= sum_next;
        flags_reg.neg  <= neg2_reg;
        flags_reg.zero <= zero_next;
    end

    assign out_valid = valid_reg[2];
    assign out_sum   = sum_reg;
    assign out_mag   = mag3_reg;
    assign out_flags = flags_reg;

endmodule

// ----- design/qn_sqrt.sv -----
// ----------------------------------------------------------------------------
// qn_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module qn_sqrt #(
    parameter int RW = 31,
    parameter int SW = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [2*RW-1:0]   in_rad,
    input  logic [SW-1:0]     in_side,
    output logic              out_valid,
    output logic [RW-1:0]     out_root,
    output logic [SW-1:0]     out_side
);

    localparam int IW = 2 * RW;

    logic [IW-1:0] rem_in   [0:RW-1];
    logic [RW-1:0] root_in  [0:RW-1];
    logic [SW-1:0] side_in  [0:RW-1];
    logic          valid_in [0:RW-1];
    logic [IW-1:0] rem_reg  [0:RW-1];
    logic [RW-1:0] root_reg [0:RW-1];
    logic [SW-1:0] side_reg [0:RW-1];
    logic [RW-1:0] valid_reg;

    assign rem_in[0]   = in_rad;
    assign root_in[0]  = '0;
    assign side_in[0]  = in_side;
    assign valid_in[0] = in_valid;

    for (genvar k = 0; k < RW; k++)
    begin : g_stage
        localparam int B = RW - 1 - k;
        logic [IW-1:0] trial;

        if (k > 0)
        begin : g_link
            assign rem_in[k]   = rem_reg[k-1];
            assign root_in[k]  = root_reg[k-1];
            assign side_in[k]  = side_reg[k-1];
            assign valid_in[k] = valid_reg[k-1];
        end

        // (2*root + 2^B) * 2^B, root holds only bits above B
        assign trial = (IW'(root_in[k]) << (B + 1)) | (IW'(1) << (2 * B));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= valid_in[k];
            end
        end

        always_ff @(posedge clk)
        begin
            side_reg[k] <= side_in[k];
            if (rem_in[k] >= trial)
            begin
                rem_reg[k]  <= rem_in[k] - trial;
                root_reg[k] <= root_in[k] | (RW'(1) << B);
            end
            else
            begin
                rem_reg[k]  <= rem_in[k];
                root_reg[k] <= root_in[k];
            end
        end
    end

    assign out_valid = valid_reg[RW-1];
    assign out_root  = root_reg[RW-1];
    assign out_side  = side_reg[RW-1];

endmodule

// ----- design/qn_div.sv -----
// ----------------------------------------------------------------------------
// qn_div
// Four-lane pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module qn_div #(
    parameter int CW = qn_pkg::COMPONENT_WIDTH,
    parameter int FB = qn_pkg::FRACTION_BITS,
    parameter int MW = CW + FB + 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [MW-1:0]                 in_div,
    input  logic [qn_pkg::LANES*CW-1:0]   in_mag,
    input  qn_pkg::qn_flags_t             in_flags,
    output logic                          out_valid,
    output logic [qn_pkg::LANES*(FB+2)-1:0] out_quo,
    output qn_pkg::qn_flags_t             out_flags
);

    localparam int L  = qn_pkg::LANES;
    localparam int QW = FB + 2;
    localparam int XW = MW + QW;

    logic [L*XW-1:0]   rem_in    [0:QW-1];
    logic [L*QW-1:0]   quo_in    [0:QW-1];
    logic [MW-1:0]     div_in    [0:QW-1];
    qn_pkg::qn_flags_t flags_in  [0:QW-1];
    logic              valid_in  [0:QW-1];
    logic [L*XW-1:0]   rem_reg   [0:QW-1];
    logic [L*QW-1:0]   quo_reg   [0:QW-1];
    logic [MW-1:0]     div_reg   [0:QW-1];
    qn_pkg::qn_flags_t flags_reg [0:QW-1];
    logic [QW-1:0]     valid_reg;

    // dividend is mag * 2^(2*FB)
    for (genvar i = 0; i < L; i++)
    begin : g_load
        assign rem_in[0][i*XW +: XW] = XW'(in_mag[i*CW +: CW]) << (2 * FB);
    end
    assign quo_in[0]   = '0;
    assign div_in[0]   = in_div;
    assign flags_in[0] = in_flags;
    assign valid_in[0] = in_valid;

    for (genvar k = 0; k < QW; k++)
    begin : g_stage
        localparam int B = QW - 1 - k;
        logic [XW-1:0] trial;

        if (k > 0)
        begin : g_link
            assign rem_in[k]   = rem_reg[k-1];
            assign quo_in[k]   = quo_reg[k-1];
            assign div_in[k]   = div_reg[k-1];
            assign flags_in[k] = flags_reg[k-1];
            assign valid_in[k] = valid_reg[k-1];
        end

        assign trial = XW'(div_in[k]) << B;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= valid_in[k];
            end
        end

        always_ff @(posedge clk)
        begin
            div_reg[k]   <= div_in[k];
            flags_reg[k] <= flags_in[k];
            for (int i = 0; i < L; i++)
            begin
                if (rem_in[k][i*XW +: XW] >= trial)
                begin
                    rem_reg[k][i*XW +: XW] <= rem_in[k][i*XW +: XW] - trial;
                    quo_reg[k][i*QW +: QW] <= quo_in[k][i*QW +: QW] | (QW'(1) << B);
                end
                else
                begin
                    rem_reg[k][i*XW +: XW] <= rem_in[k][i*XW +: XW];
                    quo_reg[k][i*QW +: QW] <= quo_in[k][i*QW +: QW];
                end
            end
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign out_quo   = quo_reg[QW-1];
    assign out_flags = flags_reg[QW-1];

endmodule

// ----- design/quaternion_normalize.sv -----
// ----------------------------------------------------------------------------
// quaternion_normalize
// Fixed-point quaternion normaliser: scales (w, x, y, z) to unit length.
// ----------------------------------------------------------------------------
// Usage
//   Input: present in_w..in_z and pulse start. A word is taken at any edge
//   with start high and busy low; busy is held low, so one word per cycle
//   is taken for as long as start stays high.
//   Output: done is high for exactly one cycle with out_w..out_z and
//   zero_magnitude; the receiver must take the word in that cycle.
//   Throughput: one word per cycle. Each word passes through the
//   sum-of-squares front end, the square-root pipeline (one root bit per
//   stage), the four-lane divider (one quotient bit per stage) and the
//   output register.
//   Results: comp * 2^(2*FB) / floor(sqrt(S * 2^(2*FB))), truncated and
//   clamped to +-2^FB, Q1.FB. An all-zero input gives zero outputs and
//   zero_magnitude high.
//   Reset: rst_n clears every valid bit; words in flight are dropped and
//   done stays low until a new word has crossed the pipeline.
// ----------------------------------------------------------------------------
module quaternion_normalize #(
    parameter int COMPONENT_WIDTH = qn_pkg::COMPONENT_WIDTH,
    parameter int FRACTION_BITS   = qn_pkg::FRACTION_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [COMPONENT_WIDTH-1:0]  in_w,
    input  logic signed [COMPONENT_WIDTH-1:0]  in_x,
    input  logic signed [COMPONENT_WIDTH-1:0]  in_y,
    input  logic signed [COMPONENT_WIDTH-1:0]  in_z,
    output logic                               done,
    output logic signed [FRACTION_BITS+1:0]    out_w,
    output logic signed [FRACTION_BITS+1:0]    out_x,
    output logic signed [FRACTION_BITS+1:0]    out_y,
    output logic signed [FRACTION_BITS+1:0]    out_z,
    output logic                               zero_magnitude
);

    localparam int CW = COMPONENT_WIDTH;
    localparam int FB = FRACTION_BITS;
    localparam int L  = qn_pkg::LANES;
    localparam int RW = CW + FB + 1;          // root width
    localparam int QW = FB + 2;               // quotient / output width
    localparam int FW = $bits(qn_pkg::qn_flags_t);
    localparam int SW = L * CW + FW;          // sideband through the root pipe

    logic                  ss_valid;
    logic [2*CW:0]         ss_sum;
    logic [L*CW-1:0]       ss_mag;
    qn_pkg::qn_flags_t     ss_flags;
    logic [2*RW-1:0]       rad;

    logic                  sq_valid;
    logic [RW-1:0]         sq_root;
    logic [SW-1:0]         sq_side;

    logic                  dv_valid;
    logic [L*QW-1:0]       dv_quo;
    qn_pkg::qn_flags_t     dv_flags;

    logic [QW-1:0]         res_next [0:L-1];
    logic [QW-1:0]         res_reg  [0:L-1];
    logic                  zero_reg;
    logic                  done_reg;

    // pure pipeline, never back-pressured
    assign busy = 1'b0;

    qn_sumsq #(
        .CW (CW)
    ) u_sumsq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .in_comp   ({in_z, in_y, in_x, in_w}),
        .out_valid (ss_valid),
        .out_sum   (ss_sum),
        .out_mag   (ss_mag),
        .out_flags (ss_flags)
    );

    // radicand S * 2^(2*FB)
    assign rad = (2*RW)'(ss_sum) << (2 * FB);

    qn_sqrt #(
        .RW (RW),
        .SW (SW)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ss_valid),
        .in_rad    (rad),
        .in_side   ({ss_flags, ss_mag}),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    qn_div #(
        .CW (CW),
        .FB (FB),
        .MW (RW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_valid),
        .in_div    (sq_root),
        .in_mag    (sq_side[L*CW-1:0]),
        .in_flags  (qn_pkg::qn_flags_t'(sq_side[SW-1:L*CW])),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_flags (dv_flags)
    );

    // clamp to one, restore sign; zero input forces zero
    always_comb
    begin
        logic [QW-1:0] sat;
        for (int i = 0; i < L; i++)
        begin
            sat = dv_quo[i*QW +: QW];
            if (sat > (QW'(1) << FB))
            begin
                sat = QW'(1) << FB;
            end
            if (dv_flags.zero)
            begin
                res_next[i] = '0;
            end
            else if (dv_flags.neg[i])
            begin
                res_next[i] = ~sat + 1'b1;
            end
            else
            begin
                res_next[i] = sat;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < L; i++)
        begin
            res_reg[i] <= res_next[i];
        end
        zero_reg <= dv_flags.zero;
    end

    assign done           = done_reg;
    assign out_w          = res_reg[0];
    assign out_x          = res_reg[1];
    assign out_y          = res_reg[2];
    assign out_z          = res_reg[3];
    assign zero_magnitude = zero_reg;

endmodule
